// ----- src/rau_pkg.sv -----
// ----------------------------------------------------------------------------
// rau_pkg
// shared types, opcodes and status codes of the rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int unsigned OpW    = 32;
  localparam int unsigned MagW   = 64;
  localparam int unsigned CntW   = 7;
  localparam int unsigned QDepth = 2;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_NEG  = 4'd4,
    OP_NORM = 4'd5,
    OP_EQ   = 4'd6,
    OP_GE   = 4'd7,
    OP_LE   = 4'd8,
    OP_GT   = 4'd9,
    OP_LT   = 4'd10
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CLS_DONE,
    CLS_CMP,
    CLS_ARITH
  } class_e;

  // classified word handed from the front to the back
  typedef struct packed {
    class_e            cls;
    logic [3:0]        op;
    logic [OpW-1:0]    an;
    logic [OpW-1:0]    ad;
    logic [OpW-1:0]    bn;
    logic [OpW-1:0]    bd;
    status_e           st;
  } item_t;

endpackage

// ----- src/rau_front.sv -----
// ----------------------------------------------------------------------------
// rau_front
// accepts command words, checks zero denominators and pushes classified words
// into a two-entry queue
// ----------------------------------------------------------------------------
module rau_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [3:0]              opcode_i,
  input  logic [rau_pkg::OpW-1:0] a_num_i,
  input  logic [rau_pkg::OpW-1:0] a_den_i,
  input  logic [rau_pkg::OpW-1:0] b_num_i,
  input  logic [rau_pkg::OpW-1:0] b_den_i,
  output logic                    busy_o,
  output logic                    q_valid_o,
  output rau_pkg::item_t          q_item_o,
  input  logic                    q_pop_i
);
  import rau_pkg::*;

  item_t          mem_q [QDepth];
  logic           wp_q, wp_d, rp_q, rp_d;
  logic [1:0]     cnt_q, cnt_d;
  item_t          it;
  logic           push, unary, zero;

  assign busy_o = (cnt_q == 2'(QDepth));
  assign push   = start_i && !busy_o;
  assign unary  = (opcode_i == OP_NEG) || (opcode_i == OP_NORM);
  assign zero   = (a_den_i == '0) || (!unary && b_den_i == '0) ||
                  (opcode_i == OP_DIV && b_num_i == '0);

  always_comb begin
    it.op = opcode_i;
    it.an = a_num_i;
    it.ad = a_den_i;
    it.bn = b_num_i;
    it.bd = b_den_i;
    it.st = ST_OK;
    if (opcode_i > OP_LT) begin
      it.cls = CLS_DONE;
    end else if (zero) begin
      it.cls = CLS_DONE;
      it.st  = ST_ZERO_DEN;
    end else if (opcode_i >= OP_EQ) begin
      it.cls = CLS_CMP;
    end else begin
      it.cls = CLS_ARITH;
    end
  end

  assign wp_d  = push ? ~wp_q : wp_q;
  assign rp_d  = q_pop_i ? ~rp_q : rp_q;
  assign cnt_d = cnt_q + 2'(push) - 2'(q_pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= it;
    end
  end

  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = mem_q[rp_q];
endmodule

// ----- src/rau_divider.sv -----
// ----------------------------------------------------------------------------
// rau_divider
// restoring 64-bit unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rau_divider (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     go_i,
  input  logic [rau_pkg::MagW-1:0] dividend_i,
  input  logic [rau_pkg::MagW-1:0] divisor_i,
  output logic                     done_o,
  output logic [rau_pkg::MagW-1:0] quot_o,
  output logic [rau_pkg::MagW-1:0] rem_o
);
  import rau_pkg::*;

  logic [MagW-1:0] quot_q, quot_d, dvs_q;
  logic [MagW:0]   rem_q, rem_d, trial;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            run_q, run_d, done_q, done_d;

  assign trial = {rem_q[MagW-1:0], quot_q[MagW-1]} - {1'b0, dvs_q};

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (go_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      run_d  = 1'b1;
    end else if (run_q) begin
      if (!trial[MagW]) begin
        rem_d = trial;
      end else begin
        rem_d = {rem_q[MagW-1:0], quot_q[MagW-1]};
      end
      quot_d = {quot_q[MagW-2:0], !trial[MagW]};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CntW'(MagW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (go_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q[MagW-1:0];
endmodule

// ----- src/rau_back.sv -----
// ----------------------------------------------------------------------------
// rau_back
// carries out one classified word: cross products, and for arithmetic words
// the sum, gcd by repeated division and the two reducing divisions
// ----------------------------------------------------------------------------
module rau_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_valid_i,
  input  rau_pkg::item_t          q_item_i,
  output logic                    q_pop_o,
  output logic                    done_o,
  output logic [rau_pkg::OpW-1:0] res_num_o,
  output logic [rau_pkg::OpW-2:0] res_den_o,
  output logic                    truth_o,
  output logic [1:0]              status_o
);
  import rau_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_MUL2, S_SUM, S_GCD, S_GWAIT, S_DIVN, S_NWAIT,
    S_DIVD, S_DWAIT, S_FIN
  } state_e;

  state_e          state_q, state_d;
  item_t           it_q;
  logic            pn_neg_q, pq_neg_q, dneg_q, nneg_q, cmp_q;
  logic [MagW-1:0] p_q, qq_q, d_q, n_q, x_q, y_q, nm_q;
  logic [OpW-1:0]  m1a, m1b, m2a, m2b;
  logic [MagW-1:0] prod1, prod2;
  logic [OpW-1:0]  mag_an, mag_ad, mag_bn, mag_bd;
  logic            s_an, s_ad, s_bn, s_bd;
  logic            dv_go, dv_done;
  logic [MagW-1:0] dv_a, dv_b, dv_quot, dv_rem;
  logic [MagW-1:0] lim;
  logic            nneg_f, ovf, lt, eq;
  logic [OpW-1:0]  fin_num;
  logic [OpW-2:0]  fin_den;
  logic            fin_truth;
  logic [1:0]      fin_st;
  logic [OpW-1:0]  out_num_q;
  logic [OpW-2:0]  out_den_q;
  logic [1:0]      out_st_q;
  logic            out_truth_q, done_q;

  assign lim = MagW'({1'b0, {(OpW-1){1'b1}}});

  assign s_an = it_q.an[OpW-1];
  assign s_ad = it_q.ad[OpW-1];
  assign s_bn = it_q.bn[OpW-1];
  assign s_bd = it_q.bd[OpW-1];
  assign mag_an = s_an ? -it_q.an : it_q.an;
  assign mag_ad = s_ad ? -it_q.ad : it_q.ad;
  assign mag_bn = s_bn ? -it_q.bn : it_q.bn;
  assign mag_bd = s_bd ? -it_q.bd : it_q.bd;

  // one 32x32 multiplier pair per step, operands picked by state
  always_comb begin
    m1a = mag_an;
    m1b = mag_bd;
    m2a = mag_bn;
    m2b = mag_ad;
    if (state_q == S_MUL2) begin
      m1a = mag_ad;
      m1b = mag_bd;
      if (it_q.op == OP_DIV) begin
        m1b = mag_bn;
      end
      m2a = mag_an;
      m2b = mag_bn;
    end
  end
  assign prod1 = MagW'(m1a) * MagW'(m1b);
  assign prod2 = MagW'(m2a) * MagW'(m2b);

  assign lt = ( pn_neg_q && !pq_neg_q && (p_q != '0 || qq_q != '0)) ||
              ( pn_neg_q &&  pq_neg_q && p_q > qq_q) ||
              (!pn_neg_q && !pq_neg_q && p_q < qq_q);
  assign eq = (p_q == qq_q) && (pn_neg_q == pq_neg_q || p_q == '0);

  always_comb begin
    unique case (state_q)
      S_IDLE:  state_d = q_valid_i ? S_MUL1 : S_IDLE;
      S_MUL1:  state_d = (it_q.cls == CLS_ARITH) ? S_MUL2 :
                         (it_q.cls == CLS_CMP) ? S_FIN : S_FIN;
      S_MUL2:  state_d = S_SUM;
      S_SUM:   state_d = S_GCD;
      S_GCD:   state_d = (y_q == '0) ? S_DIVN : S_GWAIT;
      S_GWAIT: state_d = dv_done ? S_GCD : S_GWAIT;
      S_DIVN:  state_d = S_NWAIT;
      S_NWAIT: state_d = dv_done ? S_DIVD : S_NWAIT;
      S_DIVD:  state_d = S_DWAIT;
      S_DWAIT: state_d = dv_done ? S_FIN : S_DWAIT;
      S_FIN:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign q_pop_o = (state_q == S_IDLE) && q_valid_i;
  assign dv_go   = (state_q == S_GCD && y_q != '0) || state_q == S_DIVN ||
                   state_q == S_DIVD;
  assign dv_a    = (state_q == S_GCD) ? x_q : (state_q == S_DIVN) ? n_q : d_q;
  assign dv_b    = (state_q == S_GCD) ? y_q : x_q;

  rau_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (dv_go),
    .dividend_i (dv_a),
    .divisor_i  (dv_b),
    .done_o     (dv_done),
    .quot_o     (dv_quot),
    .rem_o      (dv_rem)
  );

  assign nneg_f = (nm_q != '0) && (nneg_q != dneg_q);
  assign ovf    = (dv_quot > lim) || (nm_q > (nneg_f ? lim + 1'b1 : lim));

  // result word formed from the finished item
  always_comb begin
    fin_num   = '0;
    fin_den   = '0;
    fin_truth = 1'b0;
    fin_st    = it_q.st;
    if (it_q.cls == CLS_CMP) begin
      unique case (it_q.op)
        OP_EQ:   fin_truth = eq;
        OP_GE:   fin_truth = cmp_q ? (lt || eq) : !lt;
        OP_LE:   fin_truth = cmp_q ? !lt : (lt || eq);
        OP_GT:   fin_truth = cmp_q ? lt : !(lt || eq);
        default: fin_truth = cmp_q ? !(lt || eq) : lt;
      endcase
    end else if (it_q.cls == CLS_ARITH) begin
      if (ovf) begin
        fin_st = ST_OVERFLOW;
      end else begin
        fin_num = nneg_f ? -nm_q[OpW-1:0] : nm_q[OpW-1:0];
        fin_den = dv_quot[OpW-2:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_FIN);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        it_q <= q_item_i;
      end
      S_MUL1: begin
        p_q      <= prod1;
        qq_q     <= prod2;
        pn_neg_q <= (prod2 == prod2) && (prod1 != '0) && (s_an != s_bd);
        pq_neg_q <= (prod2 != '0) && ((s_bn != s_ad) != (it_q.op == OP_SUB));
        cmp_q    <= (s_ad != s_bd);
      end
      S_MUL2: begin
        if (it_q.op == OP_NEG || it_q.op == OP_NORM) begin
          d_q      <= MagW'(mag_ad);
          dneg_q   <= s_ad;
          p_q      <= MagW'(mag_an);
          pn_neg_q <= (mag_an != '0) && (s_an != (it_q.op == OP_NEG));
        end else begin
          d_q    <= prod1;
          dneg_q <= s_ad != ((it_q.op == OP_DIV) ? s_bn : s_bd);
          if (it_q.op == OP_MUL) begin
            p_q      <= prod2;
            pn_neg_q <= (prod2 != '0) && (s_an != s_bn);
          end
        end
      end
      S_SUM: begin
        if (it_q.op == OP_ADD || it_q.op == OP_SUB) begin
          if (pn_neg_q == pq_neg_q) begin
            n_q <= p_q + qq_q;
            nneg_q <= pn_neg_q;
          end else if (p_q >= qq_q) begin
            n_q <= p_q - qq_q;
            nneg_q <= pn_neg_q && (p_q != qq_q);
          end else begin
            n_q <= qq_q - p_q;
            nneg_q <= pq_neg_q;
          end
          x_q <= (pn_neg_q == pq_neg_q) ? p_q + qq_q :
                 (p_q >= qq_q) ? p_q - qq_q : qq_q - p_q;
        end else begin
          n_q    <= p_q;
          nneg_q <= pn_neg_q;
          x_q    <= p_q;
        end
        y_q <= d_q;
      end
      S_GWAIT: begin
        if (dv_done) begin
          x_q <= y_q;
          y_q <= dv_rem;
        end
      end
      S_NWAIT: begin
        if (dv_done) begin
          nm_q <= dv_quot;
        end
      end
      S_FIN: begin
        out_num_q   <= fin_num;
        out_den_q   <= fin_den;
        out_truth_q <= fin_truth;
        out_st_q    <= fin_st;
      end
      default: begin
      end
    endcase
  end

  assign done_o    = done_q;
  assign res_num_o = out_num_q;
  assign res_den_o = out_den_q;
  assign truth_o   = out_truth_q;
  assign status_o  = out_st_q;
endmodule

// ----- src/rational_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// exact fraction arithmetic and compares with gcd reduction
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. A front
// stage checks zero denominators and classifies the word into a two-entry
// queue, so two commands can be taken while the back end works. The back end
// forms the cross products on a 32x32 multiplier pair, then runs the
// Euclidean gcd on a 64-bit restoring divider and two more divisions to
// reduce. Compares and error words go from the queue through the first
// product state straight to the final state; arithmetic words also pass
// the second products, the sum, the gcd loop and the reducing divisions.
// Each result is shown for one cycle with done_o high; the receiver cannot
// stall. After reset the queue is empty and the back end idle.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [3:0]              opcode_i,
  input  logic [rau_pkg::OpW-1:0] a_num_i,
  input  logic [rau_pkg::OpW-1:0] a_den_i,
  input  logic [rau_pkg::OpW-1:0] b_num_i,
  input  logic [rau_pkg::OpW-1:0] b_den_i,
  output logic                    done_o,
  output logic [rau_pkg::OpW-1:0] res_num_o,
  output logic [rau_pkg::OpW-2:0] res_den_o,
  output logic                    truth_o,
  output logic [1:0]              status_o
);
  import rau_pkg::*;

  logic  q_valid, q_pop;
  item_t q_item;

  rau_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .opcode_i  (opcode_i),
    .a_num_i   (a_num_i),
    .a_den_i   (a_den_i),
    .b_num_i   (b_num_i),
    .b_den_i   (b_den_i),
    .busy_o    (busy),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  rau_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .done_o    (done_o),
    .res_num_o (res_num_o),
    .res_den_o (res_den_o),
    .truth_o   (truth_o),
    .status_o  (status_o)
  );
endmodule

// ----- src/rau_checker.sv -----
// ----------------------------------------------------------------------------
// rau_checker
// port-level checks of the rational arithmetic unit
// ----------------------------------------------------------------------------
module rau_checker (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start,
  input logic                    busy,
  input logic                    done_o,
  input logic [rau_pkg::OpW-1:0] res_num_o,
  input logic [rau_pkg::OpW-2:0] res_den_o,
  input logic                    truth_o,
  input logic [1:0]              status_o
);
  import rau_pkg::*;

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> status_o != 2'd3) else $error("bad status code");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != ST_OK |-> res_num_o == '0 && res_den_o == '0 && !truth_o)
    else $error("error word carries data");

  a_truth_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && truth_o |-> res_den_o == '0) else $error("compare with fraction");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result longer than one cycle");

  a_busy_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> !$isunknown(busy)) else $error("busy unknown on a command");
endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start     (start),
  .busy      (busy),
  .done_o    (done_o),
  .res_num_o (res_num_o),
  .res_den_o (res_den_o),
  .truth_o   (truth_o),
  .status_o  (status_o)
);

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the rational arithmetic unit
// ----------------------------------------------------------------------------
// A table of directed words covers the extremes, every opcode, zero
// denominators, overflow and the unused opcodes. About 2000 random words
// follow, mostly with small operands to keep the gcd short. Each result is
// checked against an in-bench model of exact fraction arithmetic or a table
// entry, with random gaps on the command side but for the last 200 words.
// ----------------------------------------------------------------------------
module tb;
  import rau_pkg::*;

  localparam logic [31:0] MaxV = 32'h7fff_ffff;
  localparam logic [31:0] MinV = 32'h8000_0000;
  localparam logic [31:0] NegOne = 32'hffff_ffff;
  localparam int NumRandom = 2000;
  localparam int CalmTail = 200;

  typedef struct {
    logic [31:0] num;
    logic [30:0] den;
    logic        truth;
    logic [1:0]  st;
  } fraction_res_t;

  typedef struct {
    logic [3:0]    op;
    logic [31:0]   an;
    logic [31:0]   ad;
    logic [31:0]   bn;
    logic [31:0]   bd;
    bit            typed;
    fraction_res_t res;
  } word_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [3:0]  opcode_i;
  logic [31:0] a_num_i, a_den_i, b_num_i, b_den_i;
  logic        done_o;
  logic [31:0] res_num_o;
  logic [30:0] res_den_o;
  logic        truth_o;
  logic [1:0]  status_o;

  fraction_res_t pending_q[$];
  bit            failed = 1'b0;

  word_row_t directed_rows[] = '{
    '{OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3, 1'b0, '{0, 0, 0, ST_OK}},
    '{OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2, 1'b1, '{32'd0, 31'd1, 1'b0, ST_OK}},
    '{OP_MUL, MinV, 32'd1, NegOne, 32'd1, 1'b1, '{0, 0, 0, ST_OVERFLOW}},
    '{OP_DIV, 32'd1, 32'd2, 32'd0, 32'd5, 1'b1, '{0, 0, 0, ST_ZERO_DEN}},
    '{OP_NEG, 32'd5, -32'sd10, 32'd0, 32'd0, 1'b1, '{32'd1, 31'd2, 1'b0, ST_OK}},
    '{OP_NORM, 32'd0, -32'sd7, MaxV, MinV, 1'b1, '{32'd0, 31'd1, 1'b0, ST_OK}},
    '{OP_NORM, MinV, MinV, 32'd3, 32'd4, 1'b1, '{32'd1, 31'd1, 1'b0, ST_OK}},
    '{OP_EQ, 32'd1, 32'd2, NegOne, -32'sd2, 1'b1, '{0, 0, 1'b1, ST_OK}},
    '{OP_GE, 32'd1, -32'sd2, 32'd1, 32'd3, 1'b0, '{0, 0, 0, ST_OK}},
    '{OP_LE, MaxV, MinV, MinV, MaxV, 1'b0, '{0, 0, 0, ST_OK}},
    '{OP_GT, MinV, NegOne, MaxV, 32'd1, 1'b0, '{0, 0, 0, ST_OK}},
    '{OP_LT, MinV, MaxV, MinV, MaxV, 1'b0, '{0, 0, 0, ST_OK}},
    '{OP_ADD, 32'd1, 32'd0, 32'd1, 32'd1, 1'b1, '{0, 0, 0, ST_ZERO_DEN}},
    '{OP_ADD, 32'd1, 32'd1, 32'd1, 32'd0, 1'b1, '{0, 0, 0, ST_ZERO_DEN}},
    '{OP_NEG, MaxV, 32'd3, 32'd1, 32'd0, 1'b0, '{0, 0, 0, ST_OK}},
    '{OP_EQ, 32'd1, 32'd1, 32'd1, 32'd0, 1'b1, '{0, 0, 0, ST_ZERO_DEN}},
    '{4'd15, MaxV, 32'd0, MinV, 32'd0, 1'b1, '{0, 0, 0, ST_OK}},
    '{4'd11, 32'd1, 32'd1, 32'd1, 32'd1, 1'b1, '{0, 0, 0, ST_OK}},
    '{OP_ADD, MaxV, 32'd1, MaxV, 32'd1, 1'b1, '{0, 0, 0, ST_OVERFLOW}},
    '{OP_MUL, 32'd1, MaxV, 32'd1, 32'd2, 1'b1, '{0, 0, 0, ST_OVERFLOW}},
    '{OP_DIV, MinV, 32'd1, NegOne, 32'd1, 1'b1, '{0, 0, 0, ST_OVERFLOW}},
    '{OP_NORM, 32'd7, MinV, 32'd0, 32'd0, 1'b1, '{0, 0, 0, ST_OVERFLOW}},
    '{OP_SUB, MinV, MaxV, MaxV, MinV, 1'b0, '{0, 0, 0, ST_OK}},
    '{OP_DIV, MaxV, MinV, MinV, MaxV, 1'b0, '{0, 0, 0, ST_OK}}
  };

  rational_arithmetic_unit DUT (
    .clk_i, .rst_ni, .start, .busy, .opcode_i, .a_num_i, .a_den_i, .b_num_i,
    .b_den_i, .done_o, .res_num_o, .res_den_o, .truth_o, .status_o
  );

  always #5 clk_i = ~clk_i;

  function automatic longint unsigned abs_of(longint x);
    return x < 0 ? longint'(-x) : longint'(x);
  endfunction

  function automatic fraction_res_t predict_fraction(logic [3:0] op,
      logic signed [31:0] an, logic signed [31:0] ad,
      logic signed [31:0] bn, logic signed [31:0] bd);
    fraction_res_t r;
    longint lhs, rhs, tmp;
    longint unsigned pm, qm, nm, dm, x, y, t;
    bit pn, qn, nneg, dneg, neg, unary;
    r.num = '0; r.den = '0; r.truth = 1'b0; r.st = ST_OK;
    unary = (op == OP_NEG) || (op == OP_NORM);
    if (op > OP_LT) return r;
    if (ad == 0 || (!unary && bd == 0) || (op == OP_DIV && bn == 0)) begin
      r.st = ST_ZERO_DEN;
      return r;
    end
    if (op >= OP_EQ) begin
      lhs = longint'(an) * longint'(bd);
      rhs = longint'(bn) * longint'(ad);
      if ((ad < 0) != (bd < 0)) begin
        tmp = lhs; lhs = rhs; rhs = tmp;
      end
      case (op)
        OP_EQ:   r.truth = lhs == rhs;
        OP_GE:   r.truth = lhs >= rhs;
        OP_LE:   r.truth = lhs <= rhs;
        OP_GT:   r.truth = lhs > rhs;
        default: r.truth = lhs < rhs;
      endcase
      return r;
    end
    dm = abs_of(ad) * abs_of(bd);
    dneg = (ad < 0) != (bd < 0);
    case (op)
      OP_ADD, OP_SUB: begin
        pm = abs_of(an) * abs_of(bd);
        pn = (pm != 0) && ((an < 0) != (bd < 0));
        qm = abs_of(bn) * abs_of(ad);
        qn = (qm != 0) && ((bn < 0) != (ad < 0));
        if (op == OP_SUB && qm != 0) qn = !qn;
        if (pn == qn) begin
          nm = pm + qm; nneg = pn;
        end else if (pm >= qm) begin
          nm = pm - qm; nneg = pn;
        end else begin
          nm = qm - pm; nneg = qn;
        end
      end
      OP_MUL: begin
        nm = abs_of(an) * abs_of(bn);
        nneg = (an < 0) != (bn < 0);
      end
      OP_DIV: begin
        nm = abs_of(an) * abs_of(bd);
        nneg = (an < 0) != (bd < 0);
        dm = abs_of(ad) * abs_of(bn);
        dneg = (ad < 0) != (bn < 0);
      end
      OP_NEG: begin
        nm = abs_of(an); nneg = an > 0;
        dm = abs_of(ad); dneg = ad < 0;
      end
      default: begin
        nm = abs_of(an); nneg = an < 0;
        dm = abs_of(ad); dneg = ad < 0;
      end
    endcase
    x = nm; y = dm;
    while (y != 0) begin
      t = x % y; x = y; y = t;
    end
    nm = nm / x;
    dm = dm / x;
    neg = (nm != 0) && (nneg != dneg);
    if (dm > 64'h7fff_ffff || nm > (neg ? 64'h8000_0000 : 64'h7fff_ffff)) begin
      r.st = ST_OVERFLOW;
      return r;
    end
    r.num = neg ? 32'(-nm) : 32'(nm);
    r.den = 31'(dm);
    return r;
  endfunction

  function automatic logic [31:0] pick_operand(bit is_den);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (is_den && sel < 3) return '0;
    if (sel < 60) return 32'($urandom_range(0, 200)) - 32'd100;
    if (sel < 85) return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
    return $urandom;
  endfunction

  task automatic send_word(logic [3:0] op, logic [31:0] an, logic [31:0] ad,
      logic [31:0] bn, logic [31:0] bd, fraction_res_t exp_res, bit allow_gap);
    int gap;
    start <= 1'b1;
    opcode_i <= op; a_num_i <= an; a_den_i <= ad; b_num_i <= bn; b_den_i <= bd;
    do @(posedge clk_i); while (busy);
    pending_q.push_back(exp_res);
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      start <= 1'b0;
      opcode_i <= 4'($urandom); a_num_i <= $urandom;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    fraction_res_t e;
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        $error("result word with no expectation waiting");
        failed = 1'b1;
      end else begin
        e = pending_q.pop_front();
        if (res_num_o !== e.num) begin
          $error("res_num expected %0d actual %0d", $signed(e.num), $signed(res_num_o));
          failed = 1'b1;
        end
        if (res_den_o !== e.den) begin
          $error("res_den expected %0d actual %0d", e.den, res_den_o);
          failed = 1'b1;
        end
        if (truth_o !== e.truth) begin
          $error("truth expected %0d actual %0d", e.truth, truth_o);
          failed = 1'b1;
        end
        if (status_o !== e.st) begin
          $error("status expected %0d actual %0d", e.st, status_o);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    #1_000_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [3:0]  op;
    logic [31:0] an, ad, bn, bd;
    fraction_res_t e;
    rst_ni <= 1'b0;
    start <= 1'b0;
    opcode_i <= '0; a_num_i <= '0; a_den_i <= '0; b_num_i <= '0; b_den_i <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_rows[i]) begin
      e = directed_rows[i].typed ? directed_rows[i].res :
          predict_fraction(directed_rows[i].op, directed_rows[i].an, directed_rows[i].ad,
                           directed_rows[i].bn, directed_rows[i].bd);
      send_word(directed_rows[i].op, directed_rows[i].an, directed_rows[i].ad,
                directed_rows[i].bn, directed_rows[i].bd, e, 1'b1);
    end
    for (int n = 0; n < NumRandom; n++) begin
      op = ($urandom_range(0, 49) == 0) ? 4'($urandom_range(11, 15))
                                        : 4'($urandom_range(0, 10));
      an = pick_operand(1'b0);
      ad = pick_operand(1'b1);
      bn = pick_operand(1'b0);
      bd = pick_operand(1'b1);
      send_word(op, an, ad, bn, bd, predict_fraction(op, an, ad, bn, bd),
                n < NumRandom - CalmTail);
    end
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
